### design/tst_pkg.sv
// timing statistics tracker package: widths, defaults and shared types
// used by tst_front, tst_back and timing_stats_tracker; no dependencies

package tst_pkg;

   localparam int NumChannelsDefault = 6;
   localparam int SampleBitsDefault  = 32;
   localparam int InputChannels      = 6;
   localparam int WordBits           = 32;
   localparam int ChanBits           = 3;
   localparam int QueueDepth         = 2;

   // one classified word handed from front to back
   typedef struct packed {
      logic                                    clear;
      logic [InputChannels-1:0][WordBits-1:0]  samples;
      logic [WordBits-1:0]                     stamp;
   } job_type;

endpackage

### design/timing_stats_tracker.sv
// timing statistics tracker: per-channel last, maximum and cumulative average
// top level; instantiates tst_front and tst_back, uses tst_pkg
//
// Request channel (req_valid / req_stall) carries one word: an action bit,
// six duration samples and a millisecond timestamp. A sample word produces
// NUM_CHANNELS response words (rsp_valid / rsp_stall), one per channel in
// channel order, rsp_is_last set on the final one. A clear word zeroes all
// statistics and produces no response.
// The front queues up to two request words, so requests are taken while the
// back is busy. The back handles one channel at a time: a multiply step and
// a 64-step serial divider set the cost. When the new count is 0 or 1 the
// divide is skipped. A clear word is handled in the idle state of the back.
// A stalled response holds its fields; the back waits and the queue fills,
// then req_stall rises. Synchronous reset clears all statistics and the
// budget register (csr_budget_us, written when csr_write is high).

module timing_stats_tracker #(
   parameter int NUM_CHANNELS = tst_pkg::NumChannelsDefault,
   parameter int SAMPLE_BITS  = tst_pkg::SampleBitsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write,
   input  logic [31:0]  csr_budget_us,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_action,
   input  logic [31:0]  req_loop_time,
   input  logic [31:0]  req_transport_time,
   input  logic [31:0]  req_send_stage_time,
   input  logic [31:0]  req_receive_sync_time,
   input  logic [31:0]  req_publish_time,
   input  logic [31:0]  req_housekeeping_time,
   input  logic [31:0]  req_timestamp_ms,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [2:0]   rsp_channel,
   output logic [31:0]  rsp_last_sample,
   output logic [31:0]  rsp_average,
   output logic [31:0]  rsp_maximum,
   output logic [31:0]  rsp_iterations,
   output logic [31:0]  rsp_over_budget_count,
   output logic [31:0]  rsp_over_budget_time,
   output logic         rsp_is_last
);

   logic [31:0] budget_ff;
   logic job_valid, job_take;
   tst_pkg::job_type job_data;

   // budget register
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= '0;
      end else if (csr_write) begin
         budget_ff <= csr_budget_us;
      end
   end

   tst_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_action, .req_loop_time,
      .req_transport_time, .req_send_stage_time, .req_receive_sync_time,
      .req_publish_time, .req_housekeeping_time, .req_timestamp_ms,
      .job_valid, .job_take, .job_data
   );

   tst_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
      .clock, .reset, .budget(budget_ff), .job_valid, .job_take, .job_data,
      .rsp_valid, .rsp_stall, .rsp_channel, .rsp_last_sample, .rsp_average,
      .rsp_maximum, .rsp_iterations, .rsp_over_budget_count,
      .rsp_over_budget_time, .rsp_is_last
   );

endmodule

### design/tst_front.sv
// front part: accepts request words, masks samples and queues them for the back part
// depends on tst_pkg

module tst_front #(
   parameter int SAMPLE_BITS = tst_pkg::SampleBitsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic [tst_pkg::WordBits-1:0]   req_loop_time,
   input  logic [tst_pkg::WordBits-1:0]   req_transport_time,
   input  logic [tst_pkg::WordBits-1:0]   req_send_stage_time,
   input  logic [tst_pkg::WordBits-1:0]   req_receive_sync_time,
   input  logic [tst_pkg::WordBits-1:0]   req_publish_time,
   input  logic [tst_pkg::WordBits-1:0]   req_housekeeping_time,
   input  logic [tst_pkg::WordBits-1:0]   req_timestamp_ms,
   output logic                           job_valid,
   input  logic                           job_take,
   output tst_pkg::job_type               job_data
);

   localparam logic [tst_pkg::WordBits-1:0] SampleMask =
      (SAMPLE_BITS >= tst_pkg::WordBits) ? {tst_pkg::WordBits{1'b1}} :
      tst_pkg::WordBits'((64'd1 << SAMPLE_BITS) - 64'd1);

   tst_pkg::job_type slot_ff [tst_pkg::QueueDepth];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   tst_pkg::job_type incoming;
   logic push, pop;

   // classify and mask the incoming word
   always_comb begin
      incoming.clear      = req_action;
      incoming.samples[0] = req_loop_time & SampleMask;
      incoming.samples[1] = req_transport_time & SampleMask;
      incoming.samples[2] = req_send_stage_time & SampleMask;
      incoming.samples[3] = req_receive_sync_time & SampleMask;
      incoming.samples[4] = req_publish_time & SampleMask;
      incoming.samples[5] = req_housekeeping_time & SampleMask;
      incoming.stamp      = req_timestamp_ms;
   end

   assign req_stall = (count_ff == 2'(tst_pkg::QueueDepth));
   assign push      = req_valid && !req_stall;
   assign job_valid = (count_ff != 2'd0);
   assign pop       = job_valid && job_take;
   assign job_data  = slot_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

### design/tst_back.sv
// back part: updates statistics channel by channel with a shared serial divider
// and emits one response word per channel for each sample word; depends on tst_pkg

module tst_back #(
   parameter int NUM_CHANNELS = tst_pkg::NumChannelsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [tst_pkg::WordBits-1:0]   budget,
   input  logic                           job_valid,
   output logic                           job_take,
   input  tst_pkg::job_type               job_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tst_pkg::ChanBits-1:0]   rsp_channel,
   output logic [tst_pkg::WordBits-1:0]   rsp_last_sample,
   output logic [tst_pkg::WordBits-1:0]   rsp_average,
   output logic [tst_pkg::WordBits-1:0]   rsp_maximum,
   output logic [tst_pkg::WordBits-1:0]   rsp_iterations,
   output logic [tst_pkg::WordBits-1:0]   rsp_over_budget_count,
   output logic [tst_pkg::WordBits-1:0]   rsp_over_budget_time,
   output logic                           rsp_is_last
);

   localparam int W  = tst_pkg::WordBits;
   localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int DW = 2 * W;
   localparam int SW = $clog2(DW + 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_START = 6'b000010,
      ST_MUL   = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_EMIT  = 6'b010000,
      ST_WAIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [W-1:0] last_ff [NUM_CHANNELS];
   logic [W-1:0] avg_ff  [NUM_CHANNELS];
   logic [W-1:0] max_ff  [NUM_CHANNELS];
   logic [W-1:0] count_ff, obt_ff, obs_ff;
   logic [CW-1:0] chan_ff;
   logic [DW-1:0] prod_ff, rem_ff, quo_ff;
   logic [SW-1:0] step_ff;
   logic [W-1:0] sample;
   logic [DW:0] rem_shift;
   logic [W-1:0] new_count;
   logic chan_done;

   // pick this channel's sample, zero beyond the input channels
   always_comb begin
      sample = '0;
      for (int i = 0; i < tst_pkg::InputChannels; i++) begin
         if (int'(chan_ff) == i) begin
            sample = job_data.samples[i];
         end
      end
   end

   assign new_count = count_ff;
   assign chan_done = (int'(chan_ff) == NUM_CHANNELS - 1);
   assign rem_shift = {rem_ff, quo_ff[DW-1]};

   // sequencer
   always_comb begin
      state_in = state_ff;
      job_take = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               if (job_data.clear) begin
                  job_take = 1'b1;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: state_in = (new_count <= W'(1)) ? ST_EMIT : ST_MUL;
         ST_MUL:   state_in = ST_DIV;
         ST_DIV:   state_in = (step_ff == SW'(1)) ? ST_EMIT : ST_DIV;
         ST_EMIT:  state_in = ST_WAIT;
         ST_WAIT: begin
            if (!rsp_stall) begin
               if (chan_done) begin
                  job_take = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid <= (state_in == ST_WAIT);
      end
   end

   // statistics and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         obt_ff   <= '0;
         obs_ff   <= '0;
         chan_ff  <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            last_ff[i] <= '0;
            avg_ff[i]  <= '0;
            max_ff[i]  <= '0;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               chan_ff <= '0;
               if (job_valid && job_data.clear) begin
                  count_ff <= '0;
                  obt_ff   <= '0;
                  obs_ff   <= '0;
                  for (int i = 0; i < NUM_CHANNELS; i++) begin
                     last_ff[i] <= '0;
                     avg_ff[i]  <= '0;
                     max_ff[i]  <= '0;
                  end
               end else if (job_valid) begin
                  count_ff <= count_ff + W'(1);
                  if (budget != '0 && job_data.samples[0] > budget) begin
                     obt_ff <= obt_ff + W'(1);
                     obs_ff <= job_data.stamp;
                  end
               end
            end
            ST_START: begin
               last_ff[chan_ff] <= sample;
               if (sample > max_ff[chan_ff]) begin
                  max_ff[chan_ff] <= sample;
               end
               if (new_count <= W'(1)) begin
                  avg_ff[chan_ff] <= sample;
               end
               prod_ff <= DW'(avg_ff[chan_ff]) * DW'(new_count - W'(1));
            end
            ST_MUL: begin
               quo_ff  <= prod_ff + DW'(sample);
               rem_ff  <= '0;
               step_ff <= SW'(DW);
            end
            ST_DIV: begin
               // one restoring step a cycle
               if (rem_shift >= (DW + 1)'(new_count)) begin
                  rem_ff <= DW'(rem_shift - (DW + 1)'(new_count));
                  quo_ff <= {quo_ff[DW-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_shift[DW-1:0];
                  quo_ff <= {quo_ff[DW-2:0], 1'b0};
               end
               step_ff <= step_ff - SW'(1);
            end
            ST_EMIT: begin
               if (new_count > W'(1)) begin
                  avg_ff[chan_ff] <= quo_ff[W-1:0];
               end
            end
            ST_WAIT: begin
               if (!rsp_stall && !chan_done) begin
                  chan_ff <= chan_ff + CW'(1);
               end
            end
            default: ;
         endcase
      end
   end

   // response fields follow the channel being shown
   assign rsp_channel           = tst_pkg::ChanBits'(chan_ff);
   assign rsp_last_sample       = last_ff[chan_ff];
   assign rsp_average           = avg_ff[chan_ff];
   assign rsp_maximum           = max_ff[chan_ff];
   assign rsp_iterations        = count_ff;
   assign rsp_over_budget_count = obt_ff;
   assign rsp_over_budget_time  = obs_ff;
   assign rsp_is_last           = chan_done;

endmodule
